/* rtl/conv3x3_rgb_zero_pad_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 RGB convolution core
// Shared immediate-consequence and next-cycle property forms, clocked on clk
// and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_RGB_ZERO_PAD_CORE_DEFINES_SVH
`define CONV3X3_RGB_ZERO_PAD_CORE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define C3X3_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("c3x3 check failed");

// Consequence must hold in the cycle after the antecedent.
`define C3X3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("c3x3 check failed");

`endif

/* rtl/c3x3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_pkg
// Types, constants and helper functions shared by the 3x3 convolution core.
// ----------------------------------------------------------------------------
package c3x3_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int SIZE_W     = 9;
	localparam int KROW_W     = 24;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_W_TOP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W_MID  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W_BOT  = 3'd4;

	localparam logic [SIZE_W-1:0] SIZE_RST  = 9'd224;
	localparam logic [KROW_W-1:0] W_TOP_RST = 24'd65274;
	localparam logic [KROW_W-1:0] W_MID_RST = 24'd66814;
	localparam logic [KROW_W-1:0] W_BOT_RST = 24'd131328;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int BYTE_W     = 8;
	localparam int LANE_W     = 9;
	localparam int PIX_W      = 27;
	localparam int COEF_W     = 8;
	localparam int PROD_W     = 17;
	localparam int SUM_W      = 20;
	localparam int POS_W      = 8;
	localparam int FIFO_DEPTH = 4;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [KROW_W-1:0] top;
		logic [KROW_W-1:0] mid;
		logic [KROW_W-1:0] bot;
	} kern_t;

	// Per-item control carried down the pipeline.
	typedef struct packed {
		logic             valid;
		logic             clr;
		logic             top_row;
		logic             emit_a;
		logic             emit_b;
		logic             last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col_a;
		logic [POS_W-1:0] col_b;
	} ctl_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] conv_red;
		logic signed [SUM_W-1:0] conv_green;
		logic signed [SUM_W-1:0] conv_blue;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic                    last;
	} res_t;

	typedef struct packed {
		logic put_a;
		logic put_b;
		res_t a;
		res_t b;
	} push_t;

	// 2*b - 255 in nine bits, two's complement.
	function automatic logic [LANE_W-1:0] center(logic [BYTE_W-1:0] b);
		return {b, 1'b0} - 9'd255;
	endfunction

	function automatic logic signed [LANE_W-1:0] lane(pix_t p, int unsigned ch);
		return $signed(p[LANE_W*ch +: LANE_W]);
	endfunction

	function automatic logic signed [COEF_W-1:0] coef(kern_t k, int unsigned r,
			int unsigned c);
		logic [KROW_W-1:0] w;
		if (r == 0)
			w = k.top;
		else if (r == 1)
			w = k.mid;
		else
			w = k.bot;
		return $signed(w[COEF_W*c +: COEF_W]);
	endfunction

endpackage

/* rtl/c3x3_line_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_line_buf
// Two line stores: the rows two above and one above the current one. Each
// column is read as its item enters and rewritten from the first stage.
// ----------------------------------------------------------------------------
module c3x3_line_buf import c3x3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_valid,
	input  logic [AW-1:0] wr_addr,
	input  logic          top_row,
	input  pix_t          pix_s1,
	output pix_t          upper_s1,
	output pix_t          lower_s1
);

	pix_t upper_mem [MAX_WIDTH];
	pix_t lower_mem [MAX_WIDTH];
	pix_t upper_wr;

	// On the first row the upper store is cleared so that row one sees padding.
	assign upper_wr = top_row ? '0 : lower_s1;

	always_ff @(posedge clk) begin
		if (en && wr_valid) begin
			upper_mem[wr_addr] <= upper_wr;
			lower_mem[wr_addr] <= pix_s1;
		end
		if (en) begin
			upper_s1 <= upper_mem[rd_addr];
			lower_s1 <= lower_mem[rd_addr];
		end
	end

endmodule

/* rtl/c3x3_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_ctrl
// Configuration registers, raster counters and the input stage: decides
// which results an item causes and registers it into the first stage.
// ----------------------------------------------------------------------------
module c3x3_ctrl import c3x3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	input  logic                  op,
	input  logic [BYTE_W-1:0]     red,
	input  logic [BYTE_W-1:0]     green,
	input  logic [BYTE_W-1:0]     blue,
	output kern_t                 kern,
	output logic [AW-1:0]         rd_addr,
	output ctl_t                  ctl_s1,
	output pix_t                  pix_s1,
	output logic [AW-1:0]         addr_s1
);

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_HEIGHT + 1);
	localparam int WCW = (CW > SIZE_W) ? CW : SIZE_W;
	localparam int HCW = (RW > SIZE_W) ? RW : SIZE_W;
	localparam int RXW = (RW > POS_W) ? RW : POS_W;
	localparam int CXW = (CW > POS_W) ? CW : POS_W;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	kern_t             kern_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     col_q;
	logic [AW-1:0]     drain_q;

	logic [WCW-1:0] w_ext;
	logic [HCW-1:0] h_ext;
	logic [CW-1:0]  w_eff;
	logic [RW-1:0]  h_eff;
	logic           is_drain;
	logic           row_done;
	logic           act;
	logic           take;
	logic           restart;
	logic           wrap;
	logic [CW-1:0]  c_raw;
	logic [CW-1:0]  c_cur;
	logic [CW-1:0]  c_next;
	logic [CW-1:0]  c_m1;
	logic [RW-1:0]  r_cur;
	logic [RW-1:0]  r_m1;
	logic [RXW-1:0] r_x;
	logic [CXW-1:0] ca_x;
	logic [CXW-1:0] cb_x;
	ctl_t           ctl_d;
	pix_t           pix_d;

	assign kern = kern_q;

	// Sizes are clamped to the range the line stores can hold.
	always_comb begin
		w_ext = WCW'(width_q);
		h_ext = HCW'(height_q);
		if (w_ext < WCW'(2))
			w_eff = CW'(2);
		else if (w_ext > WCW'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		else
			w_eff = CW'(w_ext);
		if (h_ext < HCW'(2))
			h_eff = RW'(2);
		else if (h_ext > HCW'(MAX_HEIGHT))
			h_eff = RW'(MAX_HEIGHT);
		else
			h_eff = RW'(h_ext);
	end

	always_comb begin
		is_drain = (op == OP_DRAIN);
		row_done = (row_q >= h_eff);
		// Pixels past the last row and drains before it are dropped.
		act      = is_drain ? row_done : !row_done;
		take     = pix_valid && en && act;
		c_raw    = is_drain ? CW'(drain_q) : CW'(col_q);
		r_cur    = is_drain ? h_eff : row_q;
		c_cur    = (c_raw >= w_eff) ? (w_eff - CW'(1)) : c_raw;
		c_next   = c_cur + CW'(1);
		wrap     = (c_next >= w_eff);
		c_m1     = c_cur - CW'(1);
		r_m1     = r_cur - RW'(1);
		r_x      = RXW'(r_m1);
		ca_x     = CXW'(c_m1);
		cb_x     = CXW'(c_cur);
		rd_addr  = c_cur[AW-1:0];
		pix_d    = is_drain ? '0 : {center(blue), center(green), center(red)};

		ctl_d.valid   = take;
		ctl_d.clr     = (c_cur == '0);
		ctl_d.top_row = (r_cur == '0);
		ctl_d.emit_a  = (r_cur != '0) && (c_cur != '0);
		ctl_d.emit_b  = (r_cur != '0) && (c_cur == (w_eff - CW'(1)));
		ctl_d.last    = (r_cur == h_eff);
		ctl_d.row     = r_x[POS_W-1:0];
		ctl_d.col_a   = ca_x[POS_W-1:0];
		ctl_d.col_b   = cb_x[POS_W-1:0];

		restart = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= SIZE_RST;
			height_q   <= SIZE_RST;
			kern_q.top <= W_TOP_RST;
			kern_q.mid <= W_MID_RST;
			kern_q.bot <= W_BOT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q    <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q   <= cfg_data[SIZE_W-1:0];
				REG_W_TOP:  kern_q.top <= cfg_data[KROW_W-1:0];
				REG_W_MID:  kern_q.mid <= cfg_data[KROW_W-1:0];
				REG_W_BOT:  kern_q.bot <= cfg_data[KROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			drain_q <= '0;
		end else if (restart) begin
			row_q   <= '0;
			col_q   <= '0;
			drain_q <= '0;
		end else if (take) begin
			if (!is_drain) begin
				if (wrap) begin
					col_q <= '0;
					row_q <= r_cur + RW'(1);
				end else begin
					col_q <= c_next[AW-1:0];
				end
			end else begin
				if (wrap) begin
					drain_q <= '0;
					row_q   <= '0;
					col_q   <= '0;
				end else begin
					drain_q <= c_next[AW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else if (en)
			ctl_s1 <= ctl_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= pix_d;
			addr_s1 <= c_cur[AW-1:0];
		end
	end

endmodule

/* rtl/c3x3_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_mac
// The 3x3 window, the per-channel products and the kernel sums for the
// regular output and for the right-edge output of a row.
// ----------------------------------------------------------------------------
module c3x3_mac import c3x3_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  ctl_t  ctl_s1,
	input  pix_t  pix_s1,
	input  pix_t  upper_s1,
	input  pix_t  lower_s1,
	input  kern_t kern,
	output push_t push
);

	pix_t taps_q [9];
	pix_t taps_d [9];
	ctl_t ctl_s2;
	ctl_t ctl_s3;

	logic signed [PROD_W-1:0] prod_a_d  [3][9];
	logic signed [PROD_W-1:0] prod_b_d  [3][6];
	logic signed [PROD_W-1:0] prod_a_s3 [3][9];
	logic signed [PROD_W-1:0] prod_b_s3 [3][6];
	logic signed [SUM_W-1:0]  row_a     [3][3];
	logic signed [SUM_W-1:0]  row_b     [3][3];
	logic signed [SUM_W-1:0]  sum_a     [3];
	logic signed [SUM_W-1:0]  sum_b     [3];

	// The window shifts left by one column; the first column of a row starts
	// from padding.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			taps_d[3*r]     = ctl_s1.clr ? '0 : taps_q[3*r + 1];
			taps_d[3*r + 1] = ctl_s1.clr ? '0 : taps_q[3*r + 2];
		end
		taps_d[2] = upper_s1;
		taps_d[5] = lower_s1;
		taps_d[8] = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s1.valid)
			taps_q <= taps_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// The edge output sees the window moved one more column, with padding on
	// the right.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					prod_a_d[ch][3*r + c] = coef(kern, r, c) * lane(taps_q[3*r + c], ch);
				for (int c = 0; c < 2; c++)
					prod_b_d[ch][2*r + c] = coef(kern, r, c) *
						lane(taps_q[3*r + c + 1], ch);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s3 <= prod_a_d;
			prod_b_s3 <= prod_b_d;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				row_a[ch][r] = SUM_W'(prod_a_s3[ch][3*r]) + SUM_W'(prod_a_s3[ch][3*r + 1]) +
					SUM_W'(prod_a_s3[ch][3*r + 2]);
				row_b[ch][r] = SUM_W'(prod_b_s3[ch][2*r]) + SUM_W'(prod_b_s3[ch][2*r + 1]);
			end
			sum_a[ch] = row_a[ch][0] + row_a[ch][1] + row_a[ch][2];
			sum_b[ch] = row_b[ch][0] + row_b[ch][1] + row_b[ch][2];
		end
	end

	always_comb begin
		push.put_a        = ctl_s3.valid && ctl_s3.emit_a;
		push.put_b        = ctl_s3.valid && ctl_s3.emit_b;
		push.a.conv_red   = sum_a[0];
		push.a.conv_green = sum_a[1];
		push.a.conv_blue  = sum_a[2];
		push.a.row        = ctl_s3.row;
		push.a.col        = ctl_s3.col_a;
		push.a.last       = 1'b0;
		push.b.conv_red   = sum_b[0];
		push.b.conv_green = sum_b[1];
		push.b.conv_blue  = sum_b[2];
		push.b.row        = ctl_s3.row;
		push.b.col        = ctl_s3.col_b;
		push.b.last       = ctl_s3.last;
	end

endmodule

/* rtl/c3x3_res_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_res_fifo
// Result queue: takes up to two results per cycle from the pipeline and
// hands one per transfer to the output channel.
// ----------------------------------------------------------------------------
module c3x3_res_fifo import c3x3_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  push_t push,
	input  logic  res_stall,
	output logic  res_valid,
	output res_t  res,
	output logic  space_ok
);

	localparam int PW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             mem [FIFO_DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CNT_W-1:0] count_q;
	logic             put_a;
	logic             put_b;
	logic             pop;
	logic [1:0]       n_push;

	assign put_a     = en && push.put_a;
	assign put_b     = en && push.put_b;
	assign n_push    = {1'b0, put_a} + {1'b0, put_b};
	assign res_valid = (count_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res       = mem[rp_q];
	// Room for the two results a line-end item can add.
	assign space_ok  = (count_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (put_a)
			mem[wp_q] <= push.a;
		else if (put_b)
			mem[wp_q] <= push.b;
		if (put_a && put_b)
			mem[wp_q + PW'(1)] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PW'(n_push);
			rp_q    <= rp_q + PW'(pop);
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

/* rtl/conv3x3_rgb_zero_pad_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_rgb_zero_pad_core
// Streaming 3x3 correlation of centred RGB pixels with zero padding.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_we                 cfg_index, cfg_data
//   pixel    in         pix_valid / pix_stall  op, red, green, blue
//   result   out        res_valid / res_stall  conv_*, out_row, out_col, last
//
// One pixel or drain item is taken every clock while pix_stall is low. A result
// passes the first stage, the window taps and the product registers into the
// result queue before it is presented at the output.
// A line-end item adds two results; a four-entry result queue absorbs them,
// and pix_stall is raised while it holds more than two.
// Reset clears control state only; every line store entry that reaches a
// result has already been written in the first row of the frame.
// ----------------------------------------------------------------------------
module conv3x3_rgb_zero_pad_core import c3x3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    pix_valid,
	output logic                    pix_stall,
	input  logic                    op,
	input  logic [BYTE_W-1:0]       red,
	input  logic [BYTE_W-1:0]       green,
	input  logic [BYTE_W-1:0]       blue,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic signed [SUM_W-1:0] conv_red,
	output logic signed [SUM_W-1:0] conv_green,
	output logic signed [SUM_W-1:0] conv_blue,
	output logic [POS_W-1:0]        out_row,
	output logic [POS_W-1:0]        out_col,
	output logic                    last
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic          en;
	kern_t         kern;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] addr_s1;
	ctl_t          ctl_s1;
	pix_t          pix_s1;
	pix_t          upper_s1;
	pix_t          lower_s1;
	push_t         push;
	res_t          res;

	// The whole pipeline advances together whenever the queue has room.
	assign pix_stall = !en;

	c3x3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.op        (op),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.kern      (kern),
		.rd_addr   (rd_addr),
		.ctl_s1    (ctl_s1),
		.pix_s1    (pix_s1),
		.addr_s1   (addr_s1)
	);

	c3x3_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.en       (en),
		.rd_addr  (rd_addr),
		.wr_valid (ctl_s1.valid),
		.wr_addr  (addr_s1),
		.top_row  (ctl_s1.top_row),
		.pix_s1   (pix_s1),
		.upper_s1 (upper_s1),
		.lower_s1 (lower_s1)
	);

	c3x3_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s1   (ctl_s1),
		.pix_s1   (pix_s1),
		.upper_s1 (upper_s1),
		.lower_s1 (lower_s1),
		.kern     (kern),
		.push     (push)
	);

	c3x3_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.push      (push),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res),
		.space_ok  (en)
	);

	assign conv_red   = res.conv_red;
	assign conv_green = res.conv_green;
	assign conv_blue  = res.conv_blue;
	assign out_row    = res.row;
	assign out_col    = res.col;
	assign last       = res.last;

endmodule

/* rtl/c3x3_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_checker
// Port-level checks on the convolution core, attached by bind.
// ----------------------------------------------------------------------------
`include "conv3x3_rgb_zero_pad_core_defines.svh"

module c3x3_checker import c3x3_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    pix_valid,
	input logic                    pix_stall,
	input logic                    res_valid,
	input logic                    res_stall,
	input logic signed [SUM_W-1:0] conv_red,
	input logic signed [SUM_W-1:0] conv_green,
	input logic signed [SUM_W-1:0] conv_blue,
	input logic [POS_W-1:0]        out_row,
	input logic [POS_W-1:0]        out_col,
	input logic                    last
);

	logic [3*SUM_W+2*POS_W:0] res_bits;

	assign res_bits = {conv_red, conv_green, conv_blue, out_row, out_col, last};

	// A stalled result keeps its valid and its payload.
	`C3X3_ASSERT_NEXT(res_hold_a, res_valid && res_stall, res_valid && $stable(res_bits))

	// Input back-pressure only comes from queued results.
	`C3X3_ASSERT_NOW(stall_needs_res_a, !res_valid, !pix_stall)

	// No result can be waiting straight after reset is released.
	`C3X3_ASSERT_NOW(empty_after_reset_a, $rose(arst_n), !res_valid && !pix_stall)

	// While the pixel side waits the queue must be holding a result.
	`C3X3_ASSERT_NOW(pix_wait_a, pix_valid && pix_stall, res_valid)

endmodule

bind conv3x3_rgb_zero_pad_core c3x3_checker u_c3x3_checker (.*);
